// ===== hdl/pkwrl_pkg.sv =====
// Package for the per-key fixed-window rate limiter.
// Holds the shared types, codes and sizing constants.
// No dependencies; compiled first.
package pkwrl_pkg;

   localparam int NUM_BUCKETS_DEFAULT = 64;
   localparam int KEY_W               = 64;
   localparam int SECOND_W            = 32;
   localparam int LIMIT_W             = 16;
   localparam int COUNT_W             = 17;
   localparam int VERDICT_W           = 3;
   localparam int BUCKET_IDX_W        = 6;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1000;

   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_NEW_BUCKET = 3'd0,
      VERDICT_NEW_WINDOW = 3'd1,
      VERDICT_WITHIN     = 3'd2,
      VERDICT_OVER       = 3'd3,
      VERDICT_FULL       = 3'd4
   } verdict_type;

   typedef enum logic {
      ST_IDLE    = 1'b0,
      ST_RESOLVE = 1'b1
   } ctrl_state_type;

   // One event as seen by the bucket cells
   typedef struct packed {
      logic [KEY_W-1:0]    key;
      logic [SECOND_W-1:0] second;
   } item_type;

   // Registered per-cell lookup response; all-zero when the cell missed
   typedef struct packed {
      logic                 hit;
      logic                 allowed;
      logic [VERDICT_W-1:0] verdict;
   } cell_rsp_type;

endpackage

// ===== hdl/pkwrl_if.sv =====
// Handshake channels of the rate limiter: request, response and CSR write.
// Uses pkwrl_pkg for field widths.
interface pkwrl_req_if;
   logic                             valid;
   logic                             ready;
   logic [pkwrl_pkg::KEY_W-1:0]      session_key;
   logic [pkwrl_pkg::SECOND_W-1:0]   now_second;
   modport source (output valid, output session_key, output now_second, input ready);
   modport sink   (input valid, input session_key, input now_second, output ready);
endinterface

interface pkwrl_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                allowed;
   logic [pkwrl_pkg::VERDICT_W-1:0]     verdict;
   logic [pkwrl_pkg::BUCKET_IDX_W-1:0]  bucket_index;
   modport source (output valid, output allowed, output verdict, output bucket_index,
                   input ready);
   modport sink   (input valid, input allowed, input verdict, input bucket_index,
                   output ready);
endinterface

interface pkwrl_csr_if;
   logic                             valid;
   logic                             ready;
   logic [pkwrl_pkg::LIMIT_W-1:0]    events_per_window;
   modport source (output valid, output events_per_window, input ready);
   modport sink   (input valid, input events_per_window, output ready);
endinterface

// ===== hdl/pkwrl_cell.sv =====
// One bucket of the rate limiter: key, window second, count and used mark.
// Compares against the broadcast event and updates itself on a hit; the used
// mark chains from the neighbor so the free frontier is found locally.
// Depends on pkwrl_pkg.
module pkwrl_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [pkwrl_pkg::LIMIT_W-1:0]     limit,
   input  logic                              lookup_en,
   input  pkwrl_pkg::item_type               lookup_item,
   input  logic                              claim_en,
   input  pkwrl_pkg::item_type               claim_item,
   input  logic                              prev_used,
   output logic                              used,
   output logic                              frontier,
   output pkwrl_pkg::cell_rsp_type           rsp
);
   import pkwrl_pkg::*;

   logic                 used_ff, used_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [SECOND_W-1:0]  second_ff, second_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   cell_rsp_type         rsp_ff, rsp_in;

   logic                 hit;
   logic [COUNT_W:0]     cnt_inc;
   logic [COUNT_W:0]     lim_p1;
   logic [COUNT_W:0]     cnt_sat;

   // First free cell after the used prefix
   assign frontier = !used_ff && prev_used;
   assign used     = used_ff;
   assign rsp      = rsp_ff;

   // Saturating count for a hit in the same window
   always_comb begin
      hit     = used_ff && (key_ff == lookup_item.key);
      cnt_inc = {1'b0, count_ff} + {{COUNT_W{1'b0}}, 1'b1};
      lim_p1  = {{(COUNT_W+1-LIMIT_W){1'b0}}, limit} + {{COUNT_W{1'b0}}, 1'b1};
      cnt_sat = (cnt_inc > lim_p1) ? lim_p1 : cnt_inc;
   end

   // Lookup update, claim and response
   always_comb begin
      used_in   = used_ff;
      key_in    = key_ff;
      second_in = second_ff;
      count_in  = count_ff;
      rsp_in    = rsp_ff;
      if (lookup_en) begin
         rsp_in = '0;
         if (hit) begin
            rsp_in.hit = 1'b1;
            if (second_ff != lookup_item.second) begin
               second_in      = lookup_item.second;
               count_in       = {{(COUNT_W-1){1'b0}}, 1'b1};
               rsp_in.allowed = 1'b1;
               rsp_in.verdict = VERDICT_NEW_WINDOW;
            end else begin
               count_in = cnt_sat[COUNT_W-1:0];
               if (cnt_sat <= {{(COUNT_W+1-LIMIT_W){1'b0}}, limit}) begin
                  rsp_in.allowed = 1'b1;
                  rsp_in.verdict = VERDICT_WITHIN;
               end else begin
                  rsp_in.allowed = 1'b0;
                  rsp_in.verdict = VERDICT_OVER;
               end
            end
         end
      end
      if (claim_en && frontier) begin
         used_in   = 1'b1;
         key_in    = claim_item.key;
         second_in = claim_item.second;
         count_in  = {{(COUNT_W-1){1'b0}}, 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      second_ff <= second_in;
      count_ff  <= count_in;
      rsp_ff    <= rsp_in;
   end

endmodule

// ===== hdl/per_key_fixed_window_rate_limiter_core.sv =====
// Per-key fixed-window rate limiter, top level: control, CSR and bucket row.
// Instantiates pkwrl_cell; uses pkwrl_pkg and the channels in pkwrl_if.sv.
//
// Every event passes an accept cycle and a merge cycle: in the accept cycle
// all NUM_BUCKETS cells compare the key at once and a hitting cell updates
// its own window and count; in the next cycle the cell responses are merged
// and, on a miss, the first free cell claims the key. A new event is taken
// only after the previous one has been resolved; a held response stalls the
// merge cycle. Buckets fill in order and are never freed, so the used
// marks form a prefix that resets to empty at once (no clearing pass).
// bucket_index gives the low six bits of the bucket number. CSR writes are
// always ready and must be issued only while no event is in flight.
module per_key_fixed_window_rate_limiter_core #(
   parameter int NUM_BUCKETS = pkwrl_pkg::NUM_BUCKETS_DEFAULT
) (
   input  logic   clock,
   input  logic   reset,
   pkwrl_req_if.sink    req_chan,
   pkwrl_rsp_if.source  rsp_chan,
   pkwrl_csr_if.sink    csr_chan
);
   import pkwrl_pkg::*;

   localparam int IdxW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

   ctrl_state_type            state_ff, state_in;
   logic [LIMIT_W-1:0]        limit_ff, limit_in;
   item_type                  hold_ff, hold_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_allowed_ff, rsp_allowed_in;
   verdict_type               rsp_verdict_ff, rsp_verdict_in;
   logic [BUCKET_IDX_W-1:0]   rsp_idx_ff, rsp_idx_in;

   item_type                  lookup_item;
   logic                      req_fire, rsp_fire, csr_fire;
   logic                      resolve_done;
   logic                      claim_en;

   logic [NUM_BUCKETS-1:0]    used_vec, frontier_vec, hit_vec, prev_used_vec;
   cell_rsp_type              cell_rsp [NUM_BUCKETS];

   logic                      any_hit;
   logic                      hit_allowed;
   logic [VERDICT_W-1:0]      hit_verdict;
   logic [IdxW-1:0]           hit_idx, free_idx;
   logic [IdxW+BUCKET_IDX_W-1:0] hit_idx_ext, free_idx_ext;

   // Handshakes
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_fire       = rsp_valid_ff && rsp_chan.ready;
   assign csr_fire       = csr_chan.valid && csr_chan.ready;
   assign resolve_done   = (state_ff == ST_RESOLVE) && (!rsp_valid_ff || rsp_chan.ready);
   assign claim_en       = resolve_done && !any_hit;

   assign lookup_item.key    = req_chan.session_key;
   assign lookup_item.second = req_chan.now_second;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_fire) begin
            state_in = ST_RESOLVE;
         end
         ST_RESOLVE: if (resolve_done) begin
            state_in = ST_IDLE;
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // Bucket row; cell 0 sees a used neighbor so it is the frontier when empty
   assign prev_used_vec = NUM_BUCKETS'({used_vec, 1'b1});

   for (genvar g = 0; g < NUM_BUCKETS; g++) begin : g_cell
      pkwrl_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .limit       (limit_ff),
         .lookup_en   (req_fire),
         .lookup_item (lookup_item),
         .claim_en    (claim_en),
         .claim_item  (hold_ff),
         .prev_used   (prev_used_vec[g]),
         .used        (used_vec[g]),
         .frontier    (frontier_vec[g]),
         .rsp         (cell_rsp[g])
      );
      assign hit_vec[g] = cell_rsp[g].hit;
   end

   // Merge the cell responses; at most one cell hits, missing cells are zero
   always_comb begin
      any_hit     = 1'b0;
      hit_allowed = 1'b0;
      hit_verdict = '0;
      hit_idx     = '0;
      free_idx    = '0;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
         any_hit     = any_hit | cell_rsp[i].hit;
         hit_allowed = hit_allowed | cell_rsp[i].allowed;
         hit_verdict = hit_verdict | cell_rsp[i].verdict;
         hit_idx     = hit_idx | (cell_rsp[i].hit ? IdxW'(i) : '0);
         free_idx    = free_idx | (frontier_vec[i] ? IdxW'(i) : '0);
      end
      hit_idx_ext  = (IdxW+BUCKET_IDX_W)'(hit_idx);
      free_idx_ext = (IdxW+BUCKET_IDX_W)'(free_idx);
   end

   // Output register, CSR and held event
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_allowed_in = rsp_allowed_ff;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_idx_in     = rsp_idx_ff;
      limit_in       = limit_ff;
      hold_in        = hold_ff;
      if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
      if (resolve_done) begin
         rsp_valid_in = 1'b1;
         priority if (any_hit) begin
            rsp_allowed_in = hit_allowed;
            rsp_verdict_in = verdict_type'(hit_verdict);
            rsp_idx_in     = hit_idx_ext[BUCKET_IDX_W-1:0];
         end else if (used_vec[NUM_BUCKETS-1]) begin
            rsp_allowed_in = 1'b0;
            rsp_verdict_in = VERDICT_FULL;
            rsp_idx_in     = '0;
         end else begin
            rsp_allowed_in = 1'b1;
            rsp_verdict_in = VERDICT_NEW_BUCKET;
            rsp_idx_in     = free_idx_ext[BUCKET_IDX_W-1:0];
         end
      end
      if (csr_fire) begin
         limit_in = csr_chan.events_per_window;
      end
      if (req_fire) begin
         hold_in = lookup_item;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.allowed      = rsp_allowed_ff;
   assign rsp_chan.verdict      = rsp_verdict_ff;
   assign rsp_chan.bucket_index = rsp_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff        <= hold_in;
      rsp_allowed_ff <= rsp_allowed_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_idx_ff     <= rsp_idx_in;
   end

`ifndef SYNTH
   // Keys are unique among used buckets, so a lookup hits at most one cell
   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESOLVE) |-> $onehot0(hit_vec))
      else $error("more than one bucket matched the key");

   // Used buckets form a prefix: exactly one free frontier unless full
   a_prefix: assert property (@(posedge clock) disable iff (reset)
      used_vec[NUM_BUCKETS-1] ? (frontier_vec == '0) : $onehot(frontier_vec))
      else $error("used marks are not a contiguous prefix");

   // A response appears only at the end of a merge cycle
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESOLVE))
      else $error("response raised outside the merge cycle");
`endif

endmodule
